FILE: rtl/sobel_edge_magnitude_assert.svh
// ----------------------------------------------------------------------------
// Sobel edge magnitude assertion macros
// Shared property templates used by the port checker of the edge filter.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SEM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("edge filter check failed: same-cycle implication");

// Next-cycle implication, quiet while reset is asserted.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("edge filter check failed: next-cycle implication");

`endif

FILE: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Field widths, register map, reset values and shared types of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

	localparam int PIX_W   = 8;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 11;
	localparam int CFG_W_W = 12;
	localparam int CFG_H_W = 13;

	// Largest frame height the row counter can follow.
	localparam logic [CFG_H_W-1:0] ROW_LIMIT = 13'd4096;

	localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
	localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

	// Register index as seen on the configuration port (byte address / 4).
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// Write-back of one column into both line stores.
	typedef struct packed {
		logic             en;
		logic             two_en;
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] two_above;
	} line_wr_t;

endpackage

`default_nettype wire

FILE: rtl/sem_line_store.sv
// ----------------------------------------------------------------------------
// Sobel line store
// Two single-port-read line memories holding the previous two image rows.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_line_store import sem_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire line_wr_t         wr,
	output logic      [PIX_W-1:0] rd_above,
	output logic      [PIX_W-1:0] rd_two_above
);

	logic [PIX_W-1:0] above_mem [DEPTH];
	logic [PIX_W-1:0] two_mem   [DEPTH];

	// Read data is registered and holds while no new read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_above     <= above_mem[rd_addr];
			rd_two_above <= two_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			above_mem[wr_addr] <= wr.above;
		end
		if (wr.en && wr.two_en) begin
			two_mem[wr_addr] <= wr.two_above;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel filter giving (|Gx|+|Gy|)/2, saturated to 255.
// ----------------------------------------------------------------------------
// Usage: grayscale pixels enter in raster order on the s_axis channel, one
// per transaction. Results leave on the m_axis channel one row late, each
// carrying its row and column; border pixels pass through unchanged, and the
// whole image passes through when either dimension is below three.
// Each input pixel causes zero to three results; tlast marks the final
// result of a pixel and tuser marks the final pixel of the frame.
// Path: a pixel's first result reaches m_axis through the line store read,
// the gradient stage and the output register.
// Throughput: one result per cycle while the receiver accepts, so one pixel
// per cycle at best. Below the first row the last pixel of a row yields two
// results; in the last row of a taller frame a pixel yields two (one at the
// first column, three at the last) and the input waits while extras leave.
// Configuration: image_width at byte address 0, image_height at address 4.
// A write restarts the frame at pixel (0,0); write only while the stream is
// idle. Reset restores 640 x 480 and restarts the frame; the line stores are
// not cleared, since a row is always written before it is read back.
// When the receiver stalls, the output register holds its transaction, the
// result stage fills, and s_axis_tready drops until the jam clears.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude import sem_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input pixel stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] pixel_in
	// Result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // [7:0] pixel_out, [19:8] out_row,
	                                        // [30:20] out_col, [31] zero
	output logic             m_axis_tlast,  // run_last
	output logic      [0:0]  m_axis_tuser,  // [0] frame_end
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// Column address width and a width wide enough to hold the row length.
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WEW = ($clog2(MAX_WIDTH + 1) > CFG_W_W) ? $clog2(MAX_WIDTH + 1) : CFG_W_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [CFG_W_W-1:0] image_width_q;
	logic [CFG_H_W-1:0] image_height_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[CFG_W_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[CFG_H_W-1:0];
				default:          image_width_q  <= image_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
			default:          prdata = '0;
		endcase
	end

	// Effective dimensions: zero counts as one, oversize is clamped.
	logic [WEW-1:0]     width_ext;
	logic [WEW-1:0]     w_eff;
	logic [WEW-1:0]     w_last;
	logic [CFG_H_W-1:0] h_eff;
	logic [CFG_H_W-1:0] h_last;
	logic               dims_ok;

	assign width_ext = WEW'(image_width_q);

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WEW'(1);
		end else if (width_ext > WEW'(MAX_WIDTH)) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = width_ext;
		end
		if (image_height_q == '0) begin
			h_eff = CFG_H_W'(1);
		end else if (image_height_q > ROW_LIMIT) begin
			h_eff = ROW_LIMIT;
		end else begin
			h_eff = image_height_q;
		end
	end

	assign w_last  = w_eff - WEW'(1);
	assign h_last  = h_eff - CFG_H_W'(1);
	assign dims_ok = (w_eff >= WEW'(3)) && (h_eff >= CFG_H_W'(3));

	// ------------------------------------------------------------------
	// Stage 0: accept, position counters, line store read
	// ------------------------------------------------------------------
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] r0;
	logic [CW-1:0]    c0;
	logic             pos_oor;
	logic             col_is_last;
	logic             row_is_last;
	logic             accept;
	logic             s1_valid_q;
	logic             s1_adv;
	logic             s2_free;

	// A position outside the current frame size restarts at the origin.
	assign pos_oor     = (CFG_H_W'(row_q) >= h_eff) || (WEW'(col_q) >= w_eff);
	assign r0          = pos_oor ? '0 : row_q;
	assign c0          = pos_oor ? '0 : col_q;
	assign col_is_last = (WEW'(c0) == w_last);
	assign row_is_last = (CFG_H_W'(r0) == h_last);

	assign s_axis_tready = !s1_valid_q || s2_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_is_last) begin
				col_q <= '0;
				row_q <= row_is_last ? '0 : r0 + ROW_W'(1);
			end else begin
				col_q <= c0 + CW'(1);
				row_q <= r0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: read data returns, window update, gradients, write-back
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] p_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;
	logic             has_a_s1, has_b_s1, has_c_s1;
	logic             interior_s1, r_ge1_s1, r_ge2_s1, fe_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_above_s1, fwd_two_s1;

	logic [PIX_W-1:0] rd_above, rd_two_above;
	logic [PIX_W-1:0] mid, top;
	logic [PIX_W-1:0] win_q [6];
	line_wr_t         line_wr;

	// With a one-pixel row the read of the next pixel meets the write-back of
	// this one at the same column; the written values are then forwarded.
	logic fwd_hit;
	assign fwd_hit = s1_adv && (col_s1 == c0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1         <= s_axis_tdata;
			row_s1       <= r0;
			col_s1       <= c0;
			has_a_s1     <= (r0 != '0) && (c0 != '0);
			has_b_s1     <= (r0 != '0) && col_is_last;
			has_c_s1     <= row_is_last;
			// The window lies inside the row once the column is two or more,
			// since the column never passes the last one.
			interior_s1  <= dims_ok && (r0[ROW_W-1:1] != '0) && (c0[CW-1:1] != '0);
			r_ge1_s1     <= (r0 != '0);
			r_ge2_s1     <= (r0[ROW_W-1:1] != '0);
			fe_s1        <= row_is_last && col_is_last;
			fwd_s1       <= fwd_hit;
			fwd_above_s1 <= p_s1;
			fwd_two_s1   <= mid;
		end
	end

	sem_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk          (clk),
		.rd_en        (accept),
		.rd_addr      (c0),
		.wr_addr      (col_s1),
		.wr           (line_wr),
		.rd_above     (rd_above),
		.rd_two_above (rd_two_above)
	);

	// Rows that do not exist yet read as zero.
	assign mid = r_ge1_s1 ? (fwd_s1 ? fwd_above_s1 : rd_above)   : '0;
	assign top = r_ge2_s1 ? (fwd_s1 ? fwd_two_s1 : rd_two_above) : '0;

	assign line_wr.en        = s1_adv;
	assign line_wr.two_en    = r_ge1_s1;
	assign line_wr.above     = p_s1;
	assign line_wr.two_above = mid;

	// Window: entries 0..2 left column, 3..5 middle column (top, mid, bottom).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= p_s1;
		end
	end

	// Gradients: column and row weighted sums are at most 1020.
	logic [9:0]         sum_right, sum_left, sum_top, sum_bottom;
	logic signed [10:0] gx, gy;

	assign sum_right  = 10'(top) + {1'b0, mid, 1'b0} + 10'(p_s1);
	assign sum_left   = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
	assign sum_top    = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(top);
	assign sum_bottom = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(p_s1);
	assign gx         = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
	assign gy         = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bottom});

	assign s1_adv = s1_valid_q && s2_free;

	// ------------------------------------------------------------------
	// Stage 2: magnitude and result sequencing
	// ------------------------------------------------------------------
	// Pending results, bit 0 first: the pixel one row up and one column left,
	// the pixel straight above at the row end, and the pixel itself in the
	// last row.
	logic [2:0]         pend_s2;
	logic               interior_s2, fe_s2;
	logic signed [10:0] gx_s2, gy_s2;
	logic [PIX_W-1:0]   win4_s2, mid_s2, p_s2;
	logic [ROW_W-1:0]   row_s2;
	logic [CW-1:0]      col_s2;
	logic               emit;
	logic [2:0]         pend_first, pend_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (s1_adv) begin
			pend_s2 <= {has_c_s1, has_b_s1, has_a_s1};
		end else if (emit) begin
			pend_s2 <= pend_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			interior_s2 <= interior_s1;
			fe_s2       <= fe_s1;
			gx_s2       <= gx;
			gy_s2       <= gy;
			win4_s2     <= win_q[4];
			mid_s2      <= mid;
			p_s2        <= p_s1;
			row_s2      <= row_s1;
			col_s2      <= col_s1;
		end
	end

	logic [9:0]       abs_x, abs_y;
	logic [10:0]      mag_sum;
	logic [PIX_W-1:0] edge_val;

	assign abs_x    = gx_s2[10] ? 10'(-gx_s2) : 10'(gx_s2);
	assign abs_y    = gy_s2[10] ? 10'(-gy_s2) : 10'(gy_s2);
	assign mag_sum  = 11'(abs_x) + 11'(abs_y);
	assign edge_val = (mag_sum[10:9] != 2'b00) ? 8'hFF : mag_sum[8:1];

	logic             res_last;
	logic [PIX_W-1:0] res_pix;
	logic [ROW_W-1:0] res_row;
	logic [COL_W-1:0] res_col;

	assign pend_first = pend_s2 & (~pend_s2 + 3'd1);
	assign pend_next  = pend_s2 & ~pend_first;
	assign res_last   = (pend_next == '0);
	assign emit       = (pend_s2 != '0) && (!m_axis_tvalid || m_axis_tready);
	assign s2_free    = (pend_s2 == '0) || (emit && res_last);

	always_comb begin
		priority if (pend_s2[0]) begin
			res_pix = interior_s2 ? edge_val : win4_s2;
			res_row = row_s2 - ROW_W'(1);
			res_col = COL_W'(col_s2 - CW'(1));
		end else if (pend_s2[1]) begin
			res_pix = mid_s2;
			res_row = row_s2 - ROW_W'(1);
			res_col = COL_W'(col_s2);
		end else begin
			res_pix = p_s2;
			res_row = row_s2;
			res_col = COL_W'(col_s2);
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata    <= {1'b0, res_col, res_row, res_pix};
			m_axis_tlast    <= res_last;
			m_axis_tuser[0] <= res_last && fe_s2;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sem_checker.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude port checker
// Watches the result stream of the edge filter for ordering and stall rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sobel_edge_magnitude_assert.svh"

module sem_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic [0:0]  m_axis_tuser
);

	// A stalled result transaction keeps its contents.
	`SEM_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// The end of a frame is always the final result of its pixel.
	`SEM_ASSERT_IMPLY(a_frame_end_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

	// Results of one pixel leave back to back, with no gap in between.
	`SEM_ASSERT_NEXT(a_run_unbroken, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tvalid)

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

`default_nettype wire
